FILE: rtl/core/ths_pkg.sv
// Shared types and constants of the time-sliced packet histogram.
`default_nettype none
package ths_pkg;

  localparam int unsigned MS_PER_SECOND = 1000;
  localparam int unsigned DIV_W         = 10;
  localparam int unsigned DIVISOR_W     = 10;
  localparam int unsigned CNT_W         = 6;
  localparam int unsigned ADDR_W        = 5;

  // x / 1000 == (x * RECIP_MS) >> RECIP_SHIFT for every 32-bit x
  localparam logic [28:0] RECIP_MS    = 29'd274877907;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned Q1_W        = 23;
  localparam int unsigned Q2_W        = 13;

  localparam logic [2:0] REG_SLICE_MS        = 3'd0;
  localparam logic [2:0] REG_MIN_LENGTH      = 3'd1;
  localparam logic [2:0] REG_MODULE_MASK     = 3'd2;
  localparam logic [2:0] REG_TELEMETRY_CODE  = 3'd3;
  localparam logic [2:0] REG_COMMANDS_CODE   = 3'd4;
  localparam logic [2:0] REG_CONTROL_CODE    = 3'd5;
  localparam logic [2:0] REG_VIDEO_CODE      = 3'd6;
  localparam logic [2:0] REG_RETRANSMIT_MASK = 3'd7;

  typedef logic [9:0]  slice_t;
  typedef logic [11:0] length_t;
  typedef logic [7:0]  flags_t;
  typedef logic [23:0] cnt24_t;
  typedef logic [15:0] cnt16_t;

  typedef struct packed {
    cnt24_t bytes;
    cnt16_t video;
    cnt16_t video_retx;
    cnt16_t telemetry;
    cnt16_t commands;
  } entry_t;

endpackage
`default_nettype wire

FILE: rtl/core/ths_if.sv
// Input and result channel interfaces.
`default_nettype none
interface ths_in_if;
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [31:0]          time_us;
  ths_pkg::length_t     packet_length;
  ths_pkg::flags_t      pkt_flags;
  logic                 crc_ok;
  modport source (output valid, action, time_us, packet_length, pkt_flags, crc_ok,
                  input ready);
  modport sink   (input valid, action, time_us, packet_length, pkt_flags, crc_ok,
                  output ready);
endinterface

interface ths_out_if;
  logic             valid;
  logic             ready;
  logic [9:0]       slot_index;
  ths_pkg::cnt24_t  slot_bytes;
  ths_pkg::cnt16_t  slot_video;
  ths_pkg::cnt16_t  slot_video_retx;
  ths_pkg::cnt16_t  slot_telemetry;
  ths_pkg::cnt16_t  slot_commands;
  ths_pkg::cnt24_t  last_second_packets;
  logic [31:0]      last_second_bytes;
  logic             accepted;
  modport source (output valid, slot_index, slot_bytes, slot_video, slot_video_retx,
                  slot_telemetry, slot_commands, last_second_packets,
                  last_second_bytes, accepted, input ready);
  modport sink   (input valid, slot_index, slot_bytes, slot_video, slot_video_retx,
                  slot_telemetry, slot_commands, last_second_packets,
                  last_second_bytes, accepted, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/time_sliced_packet_histogram_unit.sv
// Top level of the time-sliced packet histogram.
// Each item passes in order through the accepting cycle, two reciprocal
// multiplications that divide the timestamp by 1000 twice, a state forming the
// millisecond within the second, the bit-serial divider by the slice width, a
// clearing walk over the slots passed when the slot moves, then a read and a
// write of the slot counter memory. A result still waiting in the output
// register holds the write. After reset a clearing pass writes every slot
// once before the first item is taken; register writes work meanwhile. A
// finished result sits in an output register while the next item is taken.
`default_nettype none
module time_sliced_packet_histogram_unit #(
  parameter int SLOTS = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  ths_in_if.sink                           in_ch,
  ths_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ths_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import ths_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_MOD  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_CLR  = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_UPD  = 4'd8;

  // configuration
  slice_t  slice_r;
  length_t min_len_r;
  flags_t  mod_mask_r, tel_code_r, cmd_code_r, ctl_code_r, vid_code_r, retx_mask_r;
  logic    wr_cfg;

  assign pready = 1'b1;
  assign wr_cfg = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_r     <= 10'd1;
      min_len_r   <= 12'd32;
      mod_mask_r  <= 8'd7;
      tel_code_r  <= 8'd1;
      cmd_code_r  <= 8'd2;
      ctl_code_r  <= 8'd3;
      vid_code_r  <= 8'd4;
      retx_mask_r <= 8'd128;
    end else if (wr_cfg) begin
      case (paddr[4:2])
        REG_SLICE_MS:        slice_r     <= pwdata[9:0];
        REG_MIN_LENGTH:      min_len_r   <= pwdata[11:0];
        REG_MODULE_MASK:     mod_mask_r  <= pwdata[7:0];
        REG_TELEMETRY_CODE:  tel_code_r  <= pwdata[7:0];
        REG_COMMANDS_CODE:   cmd_code_r  <= pwdata[7:0];
        REG_CONTROL_CODE:    ctl_code_r  <= pwdata[7:0];
        REG_VIDEO_CODE:      vid_code_r  <= pwdata[7:0];
        REG_RETRANSMIT_MASK: retx_mask_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SLICE_MS:        prdata = {22'd0, slice_r};
      REG_MIN_LENGTH:      prdata = {20'd0, min_len_r};
      REG_MODULE_MASK:     prdata = {24'd0, mod_mask_r};
      REG_TELEMETRY_CODE:  prdata = {24'd0, tel_code_r};
      REG_COMMANDS_CODE:   prdata = {24'd0, cmd_code_r};
      REG_CONTROL_CODE:    prdata = {24'd0, ctl_code_r};
      REG_VIDEO_CODE:      prdata = {24'd0, vid_code_r};
      REG_RETRANSMIT_MASK: prdata = {24'd0, retx_mask_r};
      default:             prdata = '0;
    endcase
  end

  // control state
  logic [3:0]    state_r;
  logic [SW-1:0] cur_r;
  logic          slot_valid_r;
  logic [SW-1:0] c_r;
  logic [SW-1:0] slot_r;
  cnt24_t        run_pkts_r, prev_pkts_r;
  logic [31:0]   run_bytes_r, prev_bytes_r;
  logic          out_valid_r;

  // latched item
  logic        act_r, crc_r;
  length_t     len_r;
  flags_t      flg_r;
  logic [31:0] time_r;

  // millisecond within the second: ms = q1 - 1000 * (q1 / 1000), q1 = time / 1000
  logic [Q1_W-1:0] q1_r;
  logic [Q2_W-1:0] q2_r;
  logic [31:0]     mul_a;
  logic [60:0]     mul_p;
  logic [Q1_W-1:0] ms_full;

  assign mul_a   = (state_r == S_MUL1) ? time_r : 32'(q1_r);
  assign mul_p   = 61'(mul_a) * 61'(RECIP_MS);
  assign ms_full = q1_r - Q1_W'(q2_r) * Q1_W'(MS_PER_SECOND);

  // divider by the slice width
  logic                 div_start;
  logic [DIV_W-1:0]     div_dvd;
  logic [DIVISOR_W-1:0] div_dsr;
  logic [CNT_W-1:0]     div_n;
  logic                 div_done;
  logic [DIV_W-1:0]     div_q;

  ths_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .nbits     (div_n),
    .done      (div_done),
    .quotient  (div_q)
  );

  logic in_take;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && (state_r == S_IDLE);

  assign div_start = (state_r == S_MOD);
  assign div_dvd   = ms_full[DIV_W-1:0];
  assign div_dsr   = (slice_r == '0) ? DIVISOR_W'(1) : slice_r;
  assign div_n     = CNT_W'(DIVISOR_W);

  // slot from the last division, clamped to the ring
  logic [31:0]   raw32;
  logic [SW-1:0] slot_new;
  assign raw32    = 32'(div_q);
  assign slot_new = (raw32 > 32'(SLOTS - 1)) ? LAST : SW'(raw32);

  logic [SW-1:0] c_inc;
  assign c_inc = (c_r == LAST) ? '0 : c_r + 1'b1;

  // slot counter memory
  entry_t        mem [SLOTS];
  entry_t        rd_data_r;
  logic          mem_we;
  logic [SW-1:0] mem_wa;
  entry_t        mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (state_r == S_RD) rd_data_r <= mem[slot_r];
  end

  // update
  logic       accept_pkt;
  flags_t     kind;
  entry_t     upd;
  logic [24:0] bsum;
  logic [32:0] rsum;
  logic        wrap;
  cnt24_t      run_pkts_base;
  logic [31:0] run_bytes_base;
  logic        out_free;

  function automatic cnt16_t inc16(input cnt16_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  assign out_free   = !out_valid_r || out_ch.ready;
  assign accept_pkt = act_r && crc_r && (len_r >= min_len_r);
  assign kind       = flg_r & mod_mask_r;
  assign wrap       = slot_valid_r && (slot_r < cur_r);
  assign run_pkts_base  = wrap ? '0 : run_pkts_r;
  assign run_bytes_base = wrap ? '0 : run_bytes_r;
  assign bsum = {1'b0, rd_data_r.bytes} + 25'(len_r);
  assign rsum = {1'b0, run_bytes_base} + 33'(len_r);

  always_comb begin
    upd = rd_data_r;
    if (accept_pkt) begin
      upd.bytes = bsum[24] ? '1 : bsum[23:0];
      if (kind == tel_code_r) begin
        upd.telemetry = inc16(rd_data_r.telemetry);
      end else if (kind == cmd_code_r || kind == ctl_code_r) begin
        upd.commands = inc16(rd_data_r.commands);
      end else if (kind == vid_code_r) begin
        if ((flg_r & retx_mask_r) != '0) upd.video_retx = inc16(rd_data_r.video_retx);
        else upd.video = inc16(rd_data_r.video);
      end
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = c_r;
    mem_wd = '0;
    if (state_r == S_INIT || state_r == S_CLR) begin
      mem_we = 1'b1;
    end else if (state_r == S_UPD && out_free) begin
      mem_we = 1'b1;
      mem_wa = slot_r;
      mem_wd = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      act_r  <= in_ch.action;
      crc_r  <= in_ch.crc_ok;
      len_r  <= in_ch.packet_length;
      flg_r  <= in_ch.pkt_flags;
      time_r <= in_ch.time_us;
    end
    if (state_r == S_MUL1) q1_r <= mul_p[RECIP_SHIFT +: Q1_W];
    if (state_r == S_MUL2) q2_r <= mul_p[RECIP_SHIFT +: Q2_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      c_r          <= '0;
      slot_r       <= '0;
      cur_r        <= '0;
      slot_valid_r <= 1'b0;
      run_pkts_r   <= '0;
      run_bytes_r  <= '0;
      prev_pkts_r  <= '0;
      prev_bytes_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (state_r == S_UPD && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_INIT: begin
          c_r <= c_inc;
          if (c_r == LAST) state_r <= S_IDLE;
        end
        S_IDLE: if (in_take) state_r <= S_MUL1;
        S_MUL1: state_r <= S_MUL2;
        S_MUL2: state_r <= S_MOD;
        S_MOD:  state_r <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            slot_r <= slot_new;
            if (!slot_valid_r) begin
              c_r     <= '0;
              state_r <= S_CLR;
            end else if (slot_new != cur_r) begin
              c_r     <= (cur_r == LAST) ? '0 : cur_r + 1'b1;
              state_r <= S_CLR;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_CLR: begin
          // walk forward, clearing up to and including the new slot
          c_r <= c_inc;
          if (c_r == slot_r) state_r <= S_RD;
        end
        S_RD: state_r <= S_UPD;
        S_UPD: begin
          if (out_free) begin
            if (wrap) begin
              prev_pkts_r  <= run_pkts_r;
              prev_bytes_r <= run_bytes_r;
            end
            if (accept_pkt) begin
              run_pkts_r  <= (run_pkts_base == '1) ? run_pkts_base : run_pkts_base + 1'b1;
              run_bytes_r <= rsum[32] ? '1 : rsum[31:0];
            end else begin
              run_pkts_r  <= run_pkts_base;
              run_bytes_r <= run_bytes_base;
            end
            cur_r        <= slot_r;
            slot_valid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state_r == S_UPD && out_free) begin
      out_ch.slot_index          <= 10'(slot_r);
      out_ch.slot_bytes          <= upd.bytes;
      out_ch.slot_video          <= upd.video;
      out_ch.slot_video_retx     <= upd.video_retx;
      out_ch.slot_telemetry      <= upd.telemetry;
      out_ch.slot_commands       <= upd.commands;
      out_ch.last_second_packets <= wrap ? run_pkts_r : prev_pkts_r;
      out_ch.last_second_bytes   <= wrap ? run_bytes_r : prev_bytes_r;
      out_ch.accepted            <= accept_pkt;
    end
  end

  assign out_ch.valid = out_valid_r;
endmodule
`default_nettype wire

FILE: rtl/core/ths_div.sv
// Restoring divider, one quotient bit per cycle, small divisor.
`default_nettype none
module ths_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [ths_pkg::DIV_W-1:0]     dividend,
  input  wire logic [ths_pkg::DIVISOR_W-1:0] divisor,
  input  wire logic [ths_pkg::CNT_W-1:0]     nbits,
  output logic                               done,
  output logic [ths_pkg::DIV_W-1:0]          quotient
);
  import ths_pkg::*;

  logic [DIV_W-1:0]     quo_r;
  logic [DIVISOR_W-1:0] rem_r;
  logic [DIVISOR_W-1:0] dsr_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;
  logic [CNT_W-1:0]     shamt;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};
  assign shamt = CNT_W'(DIV_W) - nbits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // left-align so the first step sees the top dividend bit
      quo_r <= dividend << shamt;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Testbench of the time-sliced packet histogram: directed, config and random tests.
`default_nettype none
module tb_top;
  import ths_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = 1024;

  typedef struct packed {
    logic [9:0]  slot_index;
    cnt24_t      slot_bytes;
    cnt16_t      slot_video;
    cnt16_t      slot_video_retx;
    cnt16_t      slot_telemetry;
    cnt16_t      slot_commands;
    cnt24_t      last_second_packets;
    logic [31:0] last_second_bytes;
    logic        accepted;
  } slot_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ths_in_if  in_ch ();
  ths_out_if out_ch ();

  time_sliced_packet_histogram_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow registers
  slice_t  sh_slice;
  length_t sh_min_len;
  flags_t  sh_mask, sh_tel, sh_cmd, sh_ctl, sh_vid, sh_retx;

  // shadow histogram
  cnt24_t ring_b [RING];
  cnt16_t ring_v [RING];
  cnt16_t ring_vr [RING];
  cnt16_t ring_t [RING];
  cnt16_t ring_c [RING];
  int unsigned cur_slot;
  bit have_slot;
  cnt24_t run_pkts, prev_pkts;
  logic [31:0] run_bytes, prev_bytes;

  slot_report_t pending_reports[$];
  int mismatches = 0;
  int idle_mode = 0;     // 0: sender 13/rcv 64, 1: sender 64/rcv 13, 2: none
  logic [31:0] now_us = 0;

  function automatic void wipe_slot(int unsigned s);
    ring_b[s] = '0; ring_v[s] = '0; ring_vr[s] = '0; ring_t[s] = '0; ring_c[s] = '0;
  endfunction

  function automatic cnt16_t inc16(cnt16_t v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic slot_report_t histogram_step(logic act, logic [31:0] t, length_t len,
                                                  flags_t fl, logic crc);
    int unsigned width, ms, slot, c;
    logic [8:0] kind;
    logic [32:0] sum;
    slot_report_t r;
    bit acc;
    width = (sh_slice == 0) ? 1 : sh_slice;
    ms = (t / 1000) % 1000;
    slot = ms / width;
    acc = 0;
    if (slot > RING - 1) slot = RING - 1;
    if (!have_slot || slot != cur_slot) begin
      c = have_slot ? cur_slot + 1 : 0;
      wipe_slot(slot);
      if (c >= RING) c = 0;
      while (c != slot) begin
        wipe_slot(c);
        c++;
        if (c >= RING) c = 0;
      end
    end
    if (have_slot && slot < cur_slot) begin
      prev_pkts = run_pkts; prev_bytes = run_bytes;
      run_pkts = '0; run_bytes = '0;
    end
    cur_slot = slot;
    have_slot = 1;
    if (act && crc && len >= sh_min_len) begin
      kind = fl & sh_mask;
      acc = 1;
      if (run_pkts != 24'hFFFFFF) run_pkts = run_pkts + 1;
      sum = run_bytes + len;
      run_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      sum = ring_b[slot] + len;
      ring_b[slot] = (sum > 33'hFFFFFF) ? 24'hFFFFFF : sum[23:0];
      if (kind == sh_tel) ring_t[slot] = inc16(ring_t[slot]);
      else if (kind == sh_cmd || kind == sh_ctl) ring_c[slot] = inc16(ring_c[slot]);
      else if (kind == sh_vid) begin
        if ((fl & sh_retx) != 0) ring_vr[slot] = inc16(ring_vr[slot]);
        else ring_v[slot] = inc16(ring_v[slot]);
      end
    end
    r.slot_index = slot[9:0];
    r.slot_bytes = ring_b[slot];
    r.slot_video = ring_v[slot];
    r.slot_video_retx = ring_vr[slot];
    r.slot_telemetry = ring_t[slot];
    r.slot_commands = ring_c[slot];
    r.last_second_packets = prev_pkts;
    r.last_second_bytes = prev_bytes;
    r.accepted = acc;
    return r;
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SLICE_MS:        sh_slice = val[9:0];
      REG_MIN_LENGTH:      sh_min_len = val[11:0];
      REG_MODULE_MASK:     sh_mask = val[7:0];
      REG_TELEMETRY_CODE:  sh_tel = val[7:0];
      REG_COMMANDS_CODE:   sh_cmd = val[7:0];
      REG_CONTROL_CODE:    sh_ctl = val[7:0];
      REG_VIDEO_CODE:      sh_vid = val[7:0];
      REG_RETRANSMIT_MASK: sh_retx = val[7:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic send_item(logic act, logic [31:0] t, length_t len, flags_t fl, logic crc);
    int gap;
    gap = 0;
    if (idle_mode == 0 && $urandom_range(99) < 13) gap = $urandom_range(1, 4);
    if (idle_mode == 1 && $urandom_range(99) < 64) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act; in_ch.time_us <= t; in_ch.packet_length <= len;
    in_ch.pkt_flags <= fl; in_ch.crc_ok <= crc;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    pending_reports.push_back(histogram_step(act, t, len, fl, crc));
  endtask

  task automatic set_regs(logic [31:0] sl, logic [31:0] ml, logic [31:0] mk, logic [31:0] te,
                          logic [31:0] cm, logic [31:0] ct, logic [31:0] vi, logic [31:0] rt);
    reg_write(REG_SLICE_MS, sl);
    reg_write(REG_MIN_LENGTH, ml);
    reg_write(REG_MODULE_MASK, mk);
    reg_write(REG_TELEMETRY_CODE, te);
    reg_write(REG_COMMANDS_CODE, cm);
    reg_write(REG_CONTROL_CODE, ct);
    reg_write(REG_VIDEO_CODE, vi);
    reg_write(REG_RETRANSMIT_MASK, rt);
  endtask

  task automatic test_directed();
    send_item(1'b0, 32'd0, 12'd0, 8'd0, 1'b0);          // first item, tick only
    send_item(1'b1, 32'd100, 12'd64, 8'h01, 1'b1);      // telemetry
    send_item(1'b1, 32'd200, 12'd64, 8'h02, 1'b1);      // command
    send_item(1'b1, 32'd300, 12'd64, 8'h03, 1'b1);      // link control
    send_item(1'b1, 32'd400, 12'd64, 8'h04, 1'b1);      // video
    send_item(1'b1, 32'd500, 12'd64, 8'h84, 1'b1);      // retransmitted video
    send_item(1'b1, 32'd600, 12'd64, 8'h05, 1'b1);      // unmatched kind
    send_item(1'b1, 32'd700, 12'd64, 8'h01, 1'b0);      // bad crc
    send_item(1'b1, 32'd800, 12'd31, 8'h01, 1'b1);      // one byte short
    send_item(1'b1, 32'd900, 12'd32, 8'hFF, 1'b1);      // exactly min length
    send_item(1'b1, 32'd5000, 12'd4095, 8'h00, 1'b1);   // skip slots
    send_item(1'b1, 32'd999_999, 12'd4095, 8'h04, 1'b1);// last slot of the second
    send_item(1'b1, 32'd1_000_500, 12'd100, 8'h01, 1'b1); // wrap
    send_item(1'b0, 32'd1_000_600, 12'hFFF, 8'hFF, 1'b1); // tick in same slot
    send_item(1'b1, 32'hFFFF_FFFF, 12'hFFF, 8'hFF, 1'b1);
    send_item(1'b1, 32'd0, 12'd200, 8'h02, 1'b1);         // backwards again
    wait_drained();
  endtask

  task automatic test_config_extremes();
    // overlapping codes, zero slice, zero min length, full masks
    set_regs(0, 0, 32'hFF, 32'h11, 32'h11, 32'h22, 32'h11, 32'hFF);
    send_item(1'b1, 32'd2_003_000, 12'd0, 8'h11, 1'b1);
    send_item(1'b1, 32'd2_003_100, 12'd0, 8'h22, 1'b1);
    send_item(1'b1, 32'd2_010_000, 12'd1, 8'hAA, 1'b1);
    wait_drained();
    set_regs(1000, 4095, 0, 0, 0, 0, 0, 0);
    send_item(1'b1, 32'd3_999_000, 12'd4095, 8'hFF, 1'b1);
    send_item(1'b1, 32'd4_000_000, 12'd4094, 8'hFF, 1'b1);
    send_item(1'b1, 32'd4_500_000, 12'd4095, 8'h00, 1'b1);
    wait_drained();
    set_regs(1, 32, 7, 1, 2, 3, 4, 128);
  endtask

  task automatic random_item(bit noise);
    logic [31:0] t;
    length_t len;
    flags_t fl;
    int pick;
    pick = $urandom_range(99);
    if (pick < 85) now_us = now_us + $urandom_range(0, 1500);
    else if (pick < 96) now_us = now_us + $urandom_range(0, 400_000);
    else now_us = $urandom;
    t = now_us;
    if (noise) begin
      send_item(1'($urandom_range(1)), t, 12'($urandom), 8'($urandom),
                1'($urandom_range(1)));
    end else begin
      len = 12'($urandom_range(32'(sh_min_len), 4095));
      if ($urandom_range(3) == 0) len = 12'(sh_min_len + $urandom_range(0, 8));
      case ($urandom_range(4))
        0: fl = sh_tel;
        1: fl = sh_cmd;
        2: fl = sh_ctl;
        3: fl = sh_vid;
        default: fl = 8'($urandom);
      endcase
      fl = 8'((fl & sh_mask) | ($urandom & ~sh_mask));
      send_item($urandom_range(9) != 0, t, len, fl, 1'b1);
    end
  endtask

  task automatic test_random();
    for (int m = 0; m < 3; m++) begin
      idle_mode = m;
      for (int p = 0; p < 2; p++) begin
        wait_drained();
        case ({m[1:0], p[0]})
          3'b000: set_regs(1, 32, 7, 1, 2, 3, 4, 128);
          3'b001: set_regs(1000, 0, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h80);
          3'b010: set_regs(0, 4095, 3, 1, 2, 2, 3, 8'hFF);
          3'b011: set_regs($urandom_range(2, 999), $urandom_range(0, 200), $urandom,
                           $urandom, $urandom, $urandom, $urandom, $urandom);
          3'b100: set_regs(999, 12, 8'h0F, 8'h01, 8'h02, 8'h0F, 8'h08, 8'h10);
          default: set_regs($urandom_range(1, 50), 32, 7, 1, 2, 3, 4, $urandom);
        endcase
        for (int i = 0; i < 280; i++) random_item($urandom_range(99) < 15);
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    slot_report_t want, got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.slot_index = out_ch.slot_index;
        got.slot_bytes = out_ch.slot_bytes;
        got.slot_video = out_ch.slot_video;
        got.slot_video_retx = out_ch.slot_video_retx;
        got.slot_telemetry = out_ch.slot_telemetry;
        got.slot_commands = out_ch.slot_commands;
        got.last_second_packets = out_ch.last_second_packets;
        got.last_second_bytes = out_ch.last_second_bytes;
        got.accepted = out_ch.accepted;
        if (pending_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: %p", got);
        end else begin
          want = pending_reports.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (idle_mode == 0) out_ch.ready <= ($urandom_range(99) >= 64);
      else if (idle_mode == 1) out_ch.ready <= ($urandom_range(99) >= 13);
      else out_ch.ready <= 1'b1;
    end
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.action = 1'b0; in_ch.time_us = '0;
    in_ch.packet_length = '0; in_ch.pkt_flags = '0; in_ch.crc_ok = 1'b0;
    out_ch.ready = 1'b0;
    sh_slice = 1; sh_min_len = 32; sh_mask = 7; sh_tel = 1; sh_cmd = 2; sh_ctl = 3;
    sh_vid = 4; sh_retx = 128;
    for (int i = 0; i < RING; i++) wipe_slot(i);
    cur_slot = 0; have_slot = 0;
    run_pkts = '0; run_bytes = '0; prev_pkts = '0; prev_bytes = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_extremes();
    test_random();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (mismatches == 0) $display("time_sliced_packet_histogram_unit test passed");
    else $display("time_sliced_packet_histogram_unit test failed");
    $finish;
  end

  initial begin
    #300ms;
    $display("time_sliced_packet_histogram_unit test failed");
    $finish;
  end
endmodule
`default_nettype wire
